[src/rpt_pkg.sv]
// Shared widths, types and curve coefficients for the RGB polynomial tone curve.
// No dependencies; every module of the block uses this package.
package rpt_pkg;

  // Channel and fixed-point formats
  localparam int SAMPLE_BITS = 16;
  localparam int COEF_BITS   = 24;
  localparam int SHIFT       = COEF_BITS - SAMPLE_BITS;
  localparam int CHANNELS    = 3;
  localparam int TERMS       = 6;

  // Horner accumulator: coefficient sums stay below 2^8 in Q.24, plus sign and margin
  localparam int ACC_W  = COEF_BITS + 10;
  localparam int PROD_W = ACC_W + SAMPLE_BITS + 1;

  typedef logic [SAMPLE_BITS-1:0]   sample_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  typedef sample_t [CHANNELS-1:0] sample_vec_t;
  typedef acc_t    [CHANNELS-1:0] acc_vec_t;
  typedef prod_t   [CHANNELS-1:0] prod_vec_t;

  // Data that rides along the pipeline next to the accumulators
  typedef struct packed {
    sample_vec_t x;
    sample_t     alpha;
    logic        last;
  } side_t;

  // Rounding bias for the product scale-down
  localparam prod_t HALF = prod_t'(PROD_W'(1) << (SAMPLE_BITS - 1));

  localparam longint unsigned C_ONE = 64'd1 << COEF_BITS;

  // Coefficients c1..c6 per channel (red, green, blue), signed Q.COEF_BITS,
  // rounded to nearest
  localparam acc_t CURVE_COEF [CHANNELS][TERMS] = '{
    '{  acc_t'((5954 * C_ONE + 5000) / 10000),
       -acc_t'((1492 * C_ONE + 500) / 1000),
        acc_t'((1917 * C_ONE + 50) / 100),
       -acc_t'((4504 * C_ONE + 50) / 100),
        acc_t'((4123 * C_ONE + 50) / 100),
       -acc_t'((1347 * C_ONE + 50) / 100) },
    '{  acc_t'((58 * C_ONE + 50) / 100),
       -acc_t'((3916 * C_ONE + 500) / 1000),
        acc_t'((2603 * C_ONE + 50) / 100),
       -acc_t'((5052 * C_ONE + 50) / 100),
        acc_t'((4109 * C_ONE + 50) / 100),
       -acc_t'((1228 * C_ONE + 50) / 100) },
    '{  acc_t'((3487 * C_ONE + 5000) / 10000),
       -acc_t'((1835 * C_ONE + 500) / 1000),
        acc_t'((1292 * C_ONE + 50) / 100),
       -acc_t'((1909 * C_ONE + 50) / 100),
        acc_t'((9679 * C_ONE + 500) / 1000),
       -acc_t'((1066 * C_ONE + 500) / 1000) }
  };

endpackage

[src/rpt_mul.sv]
// Pipeline stage: multiply each channel's accumulator by its sample code.
// Depends on rpt_pkg for types and widths.
module rpt_mul (
  input  logic               clk,
  input  logic               rst,
  input  logic               valid_up,
  output logic               ready_up,
  input  rpt_pkg::acc_vec_t  acc_up,
  input  rpt_pkg::side_t     side_up,
  output logic               valid_dn,
  input  logic               ready_dn,
  output rpt_pkg::prod_vec_t prod_dn,
  output rpt_pkg::side_t     side_dn
);
  import rpt_pkg::*;

  prod_vec_t prod_next;

  // Take a new transfer when empty or when the stage below drains
  assign ready_up = !valid_dn || ready_dn;

  // Signed accumulator times unsigned sample code
  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      prod_next[c] = prod_t'($signed(acc_up[c])) * prod_t'($signed({1'b0, side_up.x[c]}));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_dn <= 1'b0;
    end else if (ready_up) begin
      valid_dn <= valid_up;
    end
  end

  // Hold payload while stalled
  always_ff @(posedge clk) begin
    if (ready_up && valid_up) begin
      prod_dn <= prod_next;
      side_dn <= side_up;
    end
  end

endmodule

[src/rpt_add.sv]
// Pipeline stage: round the product back to Q.COEF_BITS and add the next coefficient.
// Depends on rpt_pkg for types, widths and the rounding bias.
module rpt_add (
  input  logic               clk,
  input  logic               rst,
  input  logic               valid_up,
  output logic               ready_up,
  input  rpt_pkg::prod_vec_t prod_up,
  input  rpt_pkg::side_t     side_up,
  input  rpt_pkg::acc_vec_t  coef,
  output logic               valid_dn,
  input  logic               ready_dn,
  output rpt_pkg::acc_vec_t  acc_dn,
  output rpt_pkg::side_t     side_dn
);
  import rpt_pkg::*;

  acc_vec_t acc_next;
  prod_t    biased;

  assign ready_up = !valid_dn || ready_dn;

  // Round to nearest, ties away from zero: negative products get one less bias
  always_comb begin
    biased = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      biased      = prod_up[c] + (prod_up[c][PROD_W-1] ? HALF - prod_t'(1) : HALF);
      acc_next[c] = $signed(biased[SAMPLE_BITS +: ACC_W]) + $signed(coef[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_dn <= 1'b0;
    end else if (ready_up) begin
      valid_dn <= valid_up;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_up && valid_up) begin
      acc_dn  <= acc_next;
      side_dn <= side_up;
    end
  end

endmodule

[src/rpt_sat.sv]
// Output stage: scale the Q.COEF_BITS result to a sample code and clamp it.
// Depends on rpt_pkg; its registers drive the block's result channel.
module rpt_sat (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 valid_up,
  output logic                 ready_up,
  input  rpt_pkg::acc_vec_t    acc_up,
  input  rpt_pkg::side_t       side_up,
  output logic                 valid_dn,
  input  logic                 ready_dn,
  output rpt_pkg::sample_vec_t y_dn,
  output rpt_pkg::sample_t     alpha_dn,
  output logic                 last_dn
);
  import rpt_pkg::*;

  sample_vec_t y_next;
  acc_t        rounded;

  assign ready_up = !valid_dn || ready_dn;

  // Clamp non-positive results to zero, round up on ties, saturate at full scale
  always_comb begin
    rounded = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      rounded = acc_up[c] + acc_t'(ACC_W'(1) << (SHIFT - 1));
      if (acc_up[c][ACC_W-1] || (acc_up[c] == '0)) begin
        y_next[c] = '0;
      end else if (|rounded[ACC_W-1:SHIFT+SAMPLE_BITS]) begin
        y_next[c] = '1;
      end else begin
        y_next[c] = rounded[SHIFT +: SAMPLE_BITS];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_dn <= 1'b0;
    end else if (ready_up) begin
      valid_dn <= valid_up;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_up && valid_up) begin
      y_dn     <= y_next;
      alpha_dn <= side_up.alpha;
      last_dn  <= side_up.last;
    end
  end

endmodule

[src/rgb_polynomial_tone_curve_core.sv]
// Top level of the RGB polynomial tone curve: Horner pipeline plus output stage.
// Depends on rpt_pkg, rpt_mul, rpt_add and rpt_sat.
//
// Usage:
//   Input channel: in_valid / in_stall with red_in, green_in, blue_in, alpha_in,
//   last_in. A pixel transfers on a rising edge with in_valid high and in_stall low.
//   Output channel: out_valid / out_stall with red_out, green_out, blue_out,
//   alpha_out, last_out, same transfer rule.
//   Each colour goes through its sixth-degree curve by Horner's rule: six
//   multiply stages interleaved with six round-and-add stages, then one clamp
//   stage that also holds the result, 13 register stages in all.
//   Throughput: one pixel per cycle while the output is not stalled; every stage holds one pixel.
//   Alpha and last ride along unchanged with their pixel.
//   Reset (rst, synchronous) empties every stage; no pixel survives it.
//   When the receiver stalls, the output holds and pixels pack into empty stages
//   behind it; in_stall rises only once all 13 stages are full.
module rgb_polynomial_tone_curve_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [rpt_pkg::SAMPLE_BITS-1:0] red_in,
  input  logic [rpt_pkg::SAMPLE_BITS-1:0] green_in,
  input  logic [rpt_pkg::SAMPLE_BITS-1:0] blue_in,
  input  logic [rpt_pkg::SAMPLE_BITS-1:0] alpha_in,
  input  logic                      last_in,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [rpt_pkg::SAMPLE_BITS-1:0] red_out,
  output logic [rpt_pkg::SAMPLE_BITS-1:0] green_out,
  output logic [rpt_pkg::SAMPLE_BITS-1:0] blue_out,
  output logic [rpt_pkg::SAMPLE_BITS-1:0] alpha_out,
  output logic                      last_out
);
  import rpt_pkg::*;

  logic        avalid [TERMS+1];
  logic        aready [TERMS+1];
  acc_vec_t    acc_s  [TERMS+1];
  side_t       aside  [TERMS+1];
  logic        mvalid [TERMS];
  logic        mready [TERMS];
  prod_vec_t   prod_s [TERMS];
  side_t       mside  [TERMS];
  acc_vec_t    coef_s [TERMS];
  sample_vec_t y;

  // Pipeline entry: accumulator starts at the highest coefficient
  assign avalid[0] = in_valid;
  assign in_stall  = !aready[0];
  assign aside[0]  = '{x: '{blue_in, green_in, red_in}, alpha: alpha_in, last: last_in};

  for (genvar c = 0; c < CHANNELS; c++) begin : g_init
    assign acc_s[0][c] = CURVE_COEF[c][TERMS-1];
  end

  // One multiply stage and one round-and-add stage per Horner step
  for (genvar k = 0; k < TERMS; k++) begin : g_step
    for (genvar c = 0; c < CHANNELS; c++) begin : g_coef
      if (k < TERMS - 1) begin : g_term
        assign coef_s[k][c] = CURVE_COEF[c][TERMS-2-k];
      end else begin : g_final
        assign coef_s[k][c] = '0;
      end
    end

    rpt_mul u_mul (
      .clk      (clk),
      .rst      (rst),
      .valid_up (avalid[k]),
      .ready_up (aready[k]),
      .acc_up   (acc_s[k]),
      .side_up  (aside[k]),
      .valid_dn (mvalid[k]),
      .ready_dn (mready[k]),
      .prod_dn  (prod_s[k]),
      .side_dn  (mside[k])
    );

    rpt_add u_add (
      .clk      (clk),
      .rst      (rst),
      .valid_up (mvalid[k]),
      .ready_up (mready[k]),
      .prod_up  (prod_s[k]),
      .side_up  (mside[k]),
      .coef     (coef_s[k]),
      .valid_dn (avalid[k+1]),
      .ready_dn (aready[k+1]),
      .acc_dn   (acc_s[k+1]),
      .side_dn  (aside[k+1])
    );
  end

  // Scale, clamp and hold the result
  rpt_sat u_sat (
    .clk      (clk),
    .rst      (rst),
    .valid_up (avalid[TERMS]),
    .ready_up (aready[TERMS]),
    .acc_up   (acc_s[TERMS]),
    .side_up  (aside[TERMS]),
    .valid_dn (out_valid),
    .ready_dn (!out_stall),
    .y_dn     (y),
    .alpha_dn (alpha_out),
    .last_dn  (last_out)
  );

  assign red_out   = y[0];
  assign green_out = y[1];
  assign blue_out  = y[2];

endmodule

[src/rpt_checker.sv]
// Port-level checks for the tone curve core, attached by the bind below.
// Depends only on rpt_pkg for the sample width.
module rpt_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [rpt_pkg::SAMPLE_BITS-1:0] red_out,
  input logic [rpt_pkg::SAMPLE_BITS-1:0] alpha_out,
  input logic                            last_out
);

  // A stalled result stays offered, with red, alpha and last unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(red_out) && $stable(alpha_out)
      && $stable(last_out))
    else $error("stalled result dropped or changed");

  // Backpressure only when the output itself is blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("in_stall raised with the output free");

  // Reset leaves nothing to deliver
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result offered right after reset");

  // An output cannot come from an input that transferred on the first edge
  // after reset into the empty block
  a_no_shortcut: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |=> !out_valid)
    else $error("result appeared too soon after reset");

endmodule

bind rgb_polynomial_tone_curve_core rpt_checker u_rpt_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .red_out   (red_out),
  .alpha_out (alpha_out),
  .last_out  (last_out)
);

[tb/tb_rgb_polynomial_tone_curve_core.sv]
`timescale 1ns / 1ps
// Self-checking bench for rgb_polynomial_tone_curve_core: Horner curve predictor and
// in-order pixel scoreboard, random gaps on input and random output stalls.
// Depends on rpt_pkg and the core RTL only.
module tb_rgb_polynomial_tone_curve_core;
  import rpt_pkg::sample_t;
  import rpt_pkg::SAMPLE_BITS;

  localparam int CURVE_SHIFT = 8;        // Q.24 accumulator down to Q0.16 output
  localparam int RANDOM_PIXELS = 1950;
  localparam int DRAIN_CYCLES = 30;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    sample_t red;
    sample_t green;
    sample_t blue;
    sample_t alpha;
    logic    last;
  } pixel_t;

  // Expected-pixel store plus a bit-exact model of the three tone curves
  class tone_scoreboard;
    pixel_t  curve_q[$];
    longint  coef[3][6];
    int      mismatches;
    int      checked;
    int      clamped_low;
    int      near_full;

    function new();
      int num[3][6] = '{'{5954, -1492, 1917, -4504, 4123, -1347},
                        '{58, -3916, 2603, -5052, 4109, -1228},
                        '{3487, -1835, 1292, -1909, 9679, -1066}};
      int den[3][6] = '{'{10000, 1000, 100, 100, 100, 100},
                        '{100, 1000, 100, 100, 100, 100},
                        '{10000, 1000, 100, 100, 1000, 1000}};
      longint mag;
      // Round each decimal coefficient to nearest in signed Q.24
      for (int c = 0; c < 3; c++) begin
        for (int k = 0; k < 6; k++) begin
          mag = ((longint'(num[c][k] < 0 ? -num[c][k] : num[c][k]) << 24) + den[c][k] / 2)
                / den[c][k];
          coef[c][k] = num[c][k] < 0 ? -mag : mag;
        end
      end
      mismatches = 0;
      checked = 0;
      clamped_low = 0;
      near_full = 0;
    endfunction

    // a * x / 2^16, rounded to nearest with ties away from zero
    function longint scaled(longint a, sample_t x);
      longint unsigned mag;
      longint unsigned p;
      mag = (a < 0) ? longint'(-a) : a;
      p = (mag * longint'(x) + 64'd32768) >> SAMPLE_BITS;
      return (a < 0) ? -longint'(p) : longint'(p);
    endfunction

    function sample_t curve(int ch, sample_t x);
      longint acc;
      longint unsigned v;
      acc = coef[ch][5];
      for (int k = 4; k >= 0; k--) acc = coef[ch][k] + scaled(acc, x);
      acc = scaled(acc, x);
      // Clamp below zero, round the Q.24 result, saturate at full scale
      if (acc <= 0) begin
        clamped_low++;
        return '0;
      end
      v = (longint'(acc) + (64'd1 << (CURVE_SHIFT - 1))) >> CURVE_SHIFT;
      if (v >= 64'hFFFF) begin
        near_full++;
        return '1;
      end
      return v[SAMPLE_BITS-1:0];
    endfunction

    function void note_pixel(pixel_t p);
      pixel_t e;
      e.red   = curve(0, p.red);
      e.green = curve(1, p.green);
      e.blue  = curve(2, p.blue);
      e.alpha = p.alpha;
      e.last  = p.last;
      curve_q.push_back(e);
    endfunction

    function void report(string what, pixel_t e, pixel_t g);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s exp r=%h g=%h b=%h a=%h l=%b got r=%h g=%h b=%h a=%h l=%b",
                 $realtime, what, e.red, e.green, e.blue, e.alpha, e.last,
                 g.red, g.green, g.blue, g.alpha, g.last);
    endfunction

    function void check_pixel(pixel_t g);
      pixel_t e;
      if (curve_q.size() == 0) begin
        e = '{default: 'x};
        report("unexpected output", e, g);
        return;
      end
      e = curve_q.pop_front();
      checked++;
      if (g.red !== e.red || g.green !== e.green || g.blue !== e.blue ||
          g.alpha !== e.alpha || g.last !== e.last)
        report("pixel mismatch", e, g);
    endfunction
  endclass

  logic    clk;
  logic    rst;
  logic    in_valid;
  logic    in_stall;
  sample_t red_in, green_in, blue_in, alpha_in;
  logic    last_in;
  logic    out_valid;
  logic    out_stall;
  sample_t red_out, green_out, blue_out, alpha_out;
  logic    last_out;

  tone_scoreboard sb;
  bit      rx_enable;
  bit      tx_calm;
  int      pixels_sent;
  int      last_flags;

  rgb_polynomial_tone_curve_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .red_in(red_in), .green_in(green_in), .blue_in(blue_in),
    .alpha_in(alpha_in), .last_in(last_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .red_out(red_out), .green_out(green_out), .blue_out(blue_out),
    .alpha_out(alpha_out), .last_out(last_out)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Mostly short idle runs, now and then a long one; none in calm stretches
  function automatic int pick_gap(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Bias channel codes toward both ends of the range
  function automatic sample_t rand_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return sample_t'($urandom_range(0, 255));
    if (r < 24) return sample_t'($urandom_range(16'hFF00, 16'hFFFF));
    return sample_t'($urandom);
  endfunction

  // Present one pixel after an optional gap and hold it until it transfers
  task automatic send_pixel(pixel_t p);
    int gap;
    gap = pick_gap(tx_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    red_in   <= p.red;
    green_in <= p.green;
    blue_in  <= p.blue;
    alpha_in <= p.alpha;
    last_in  <= p.last;
    do @(posedge clk); while (in_stall);
    sb.note_pixel(p);
    pixels_sent++;
    if (p.last) last_flags++;
  endtask

  task automatic send_rgba(sample_t r, sample_t g, sample_t b, sample_t a, logic l);
    pixel_t p;
    p.red = r;
    p.green = g;
    p.blue = b;
    p.alpha = a;
    p.last = l;
    send_pixel(p);
  endtask

  // Check on transfer; the edge just taken is seen with its pre-edge values
  task automatic sample_output();
    pixel_t g;
    @(posedge clk);
    if (rx_enable && out_valid && !out_stall) begin
      g.red = red_out;
      g.green = green_out;
      g.blue = blue_out;
      g.alpha = alpha_out;
      g.last = last_out;
      sb.check_pixel(g);
    end
  endtask

  // Receiver: alternate stall bursts and open runs, with calm stretches
  initial begin
    int n;
    int open_run;
    bit calm;
    out_stall <= 1'b0;
    calm = 1'b0;
    wait (rx_enable);
    forever begin
      if ($urandom_range(0, 19) == 0) calm = !calm;
      n = pick_gap(calm);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) sample_output();
      end
      out_stall <= 1'b0;
      open_run = $urandom_range(1, 8);
      repeat (open_run) sample_output();
    end
  end

  initial begin
    #10_000_000;
    $display("tb_rgb_polynomial_tone_curve_core: done, errors");
    $finish;
  end

  initial begin
    pixel_t p;
    sb = new();
    rx_enable = 1'b0;
    tx_calm = 1'b1;
    pixels_sent = 0;
    last_flags = 0;
    rst <= 1'b1;
    in_valid <= 1'b0;
    red_in <= '0;
    green_in <= '0;
    blue_in <= '0;
    alpha_in <= '0;
    last_in <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    rx_enable = 1'b1;
    @(posedge clk);

    // Directed: range ends, midpoints, bit patterns, alpha and last extremes
    send_rgba(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    send_rgba(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    send_rgba(16'h0001, 16'h0001, 16'h0001, 16'h0001, 1'b0);
    send_rgba(16'hFFFE, 16'hFFFE, 16'hFFFE, 16'hFFFE, 1'b1);
    send_rgba(16'h8000, 16'h7FFF, 16'h8000, 16'h8000, 1'b0);
    send_rgba(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 1'b1);
    send_rgba(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 1'b0);
    send_rgba(16'h0000, 16'hFFFF, 16'h8000, 16'hFFFF, 1'b0);
    send_rgba(16'hFFFF, 16'h0000, 16'h0001, 16'h0000, 1'b1);
    send_rgba(16'h0010, 16'h0100, 16'h1000, 16'h00FF, 1'b0);
    send_rgba(16'hF000, 16'hFF00, 16'hFFF0, 16'hFF00, 1'b0);
    send_rgba(16'h4000, 16'hC000, 16'h2000, 16'h1234, 1'b1);
    send_rgba(16'hE000, 16'h3333, 16'hCCCC, 16'hEDCB, 1'b0);
    for (int b = 0; b < SAMPLE_BITS; b += 2)
      send_rgba(sample_t'(1 << b), sample_t'(1 << (b + 1)), ~sample_t'(1 << b),
                sample_t'(1 << (b + 1)), b[1]);

    // Random: phases of back-to-back or gapped input, chosen at random
    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      if (i % 150 == 0) tx_calm = ($urandom_range(0, 2) == 0);
      p.red = rand_sample();
      p.green = rand_sample();
      p.blue = rand_sample();
      p.alpha = sample_t'($urandom);
      p.last = ($urandom_range(0, 15) == 0);
      send_pixel(p);
    end
    in_valid <= 1'b0;

    // Drain the pipeline, then watch for stray outputs
    while (sb.curve_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.curve_q.size() != 0) sb.mismatches++;

    $display("Sent %0d pixels (%0d flagged last), checked %0d results.",
             pixels_sent, last_flags, sb.checked);
    $display("Channels clamped to zero: %0d, at full scale: %0d, mismatches: %0d.",
             sb.clamped_low, sb.near_full, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("tb_rgb_polynomial_tone_curve_core: done, clean");
    end else begin
      $display("tb_rgb_polynomial_tone_curve_core: done, errors");
    end
    $finish;
  end

endmodule
